>>> hw/rtl/ufef_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ufef_pkg;

    // Number of nodes in the forest and the widths that follow from it.
    localparam int NODES    = 512;
    localparam int ADDR_W   = $clog2(NODES);
    localparam int IN_W     = 9;
    localparam int RANK_W   = 4;
    localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};

    // One memory word: the rank and the parent pointer of a node.
    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [ADDR_W-1:0] parent;
    } node_word_t;

    // Access request from the sequencer to the node memory.
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        node_word_t        wr_data;
    } mem_req_t;

endpackage

`default_nettype wire

>>> hw/rtl/online_union_find_edge_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake             Word
// -------   -------------------   ---------------------------------------
// input     in_valid / in_stall   node_a (9 bits), node_b (9 bits): one edge
// output    out_valid / out_stall joined (1 bit): edge merged two sets
//
// One edge is handled at a time. For each endpoint the memory read port walks up
// one node per cycle to the root, then walks the same path again from the endpoint,
// rewriting one node per cycle to point at the root.
// After reset a clearing pass writes every node as its own root with rank zero;
// in_stall is high during it.
// A result waiting on out_stall does not block the next edge from being accepted;
// only the finishing of that next edge waits for the output register to free up.
module online_union_find_edge_filter (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output      logic                       in_stall,
    input  wire logic [ufef_pkg::IN_W-1:0]  node_a,
    input  wire logic [ufef_pkg::IN_W-1:0]  node_b,
    output      logic                       out_valid,
    input  wire logic                       out_stall,
    output      logic                       joined
);

    ufef_pkg::mem_req_t   req;
    ufef_pkg::node_word_t rd_data;

    logic out_valid_reg, out_valid_next;
    logic joined_reg, joined_next;
    logic out_free;
    logic res_valid;
    logic res_joined;

    // The output register can take a new word when it is empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;

    ufef_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .node_a     (node_a),
        .node_b     (node_b),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res_joined (res_joined),
        .req        (req),
        .rd_data    (rd_data)
    );

    ufef_mem u_mem (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        joined_next    = joined_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            joined_next    = res_joined;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        joined_reg <= joined_next;
    end

    assign out_valid = out_valid_reg;
    assign joined    = joined_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ufef_mem.sv
`timescale 1ns / 1ps
`default_nettype none

// Node memory: one write port and one read port, read data registered.
module ufef_mem (
    input  wire logic                  clk,
    input  wire ufef_pkg::mem_req_t    req,
    output      ufef_pkg::node_word_t  rd_data
);

    ufef_pkg::node_word_t mem [ufef_pkg::NODES];
    ufef_pkg::node_word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ufef_seq.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: clearing pass, root walks, path compression and linking.
module ufef_seq (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output      logic                            in_stall,
    input  wire logic [ufef_pkg::IN_W-1:0]       node_a,
    input  wire logic [ufef_pkg::IN_W-1:0]       node_b,
    input  wire logic                            out_free,
    output      logic                            res_valid,
    output      logic                            res_joined,
    output      ufef_pkg::mem_req_t              req,
    input  wire ufef_pkg::node_word_t            rd_data
);

    localparam int AW = ufef_pkg::ADDR_W;
    localparam int RW = ufef_pkg::RANK_W;

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_UP      = 3'd2;
    localparam logic [2:0] S_CMP     = 3'd3;
    localparam logic [2:0] S_START_B = 3'd4;
    localparam logic [2:0] S_LINK    = 3'd5;
    localparam logic [2:0] S_BUMP    = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0] a_reg, a_next;
    logic [AW-1:0] b_reg, b_next;
    logic          phase_b_reg, phase_b_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [AW-1:0] root_reg, root_next;
    logic [RW-1:0] root_rank_reg, root_rank_next;
    logic [AW-1:0] ra_reg, ra_next;
    logic [RW-1:0] rank_a_reg, rank_a_next;
    logic [AW-1:0] hi_reg, hi_next;
    logic [RW-1:0] hi_rank_reg, hi_rank_next;
    logic          joined_reg, joined_next;

    logic          phase_end;
    logic [AW-1:0] fin_root;
    logic [RW-1:0] fin_rank;
    logic [AW-1:0] start_node;
    logic [AW-1:0] lo_node;
    logic [RW-1:0] lo_rank;
    logic          out_of_range;

    assign start_node   = phase_b_reg ? b_reg : a_reg;
    assign out_of_range = (32'(node_a) >= ufef_pkg::NODES) ||
                          (32'(node_b) >= ufef_pkg::NODES);
    assign res_joined   = joined_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        phase_b_next   = phase_b_reg;
        cur_next       = cur_reg;
        root_next      = root_reg;
        root_rank_next = root_rank_reg;
        ra_next        = ra_reg;
        rank_a_next    = rank_a_reg;
        hi_next        = hi_reg;
        hi_rank_next   = hi_rank_reg;
        joined_next    = joined_reg;
        req            = '0;
        in_stall       = 1'b1;
        res_valid      = 1'b0;
        phase_end      = 1'b0;
        fin_root       = root_reg;
        fin_rank       = root_rank_reg;
        lo_node        = ra_reg;
        lo_rank        = rank_a_reg;

        case (state_reg)
            S_CLEAR:
            begin
                req.wr_en          = 1'b1;
                req.wr_addr        = clr_cnt_reg;
                req.wr_data.rank   = '0;
                req.wr_data.parent = clr_cnt_reg;
                if (clr_cnt_reg == AW'(ufef_pkg::NODES - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    a_next       = node_a[AW-1:0];
                    b_next       = node_b[AW-1:0];
                    phase_b_next = 1'b0;
                    if (out_of_range)
                    begin
                        joined_next = 1'b0;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = node_a[AW-1:0];
                        cur_next    = node_a[AW-1:0];
                        state_next  = S_UP;
                    end
                end
            end
            S_UP:
            begin
                if (rd_data.parent == cur_reg)
                begin
                    // The walk has reached the root; walk the path again from its start.
                    root_next      = cur_reg;
                    root_rank_next = rd_data.rank;
                    if (start_node == cur_reg)
                    begin
                        phase_end = 1'b1;
                        fin_root  = cur_reg;
                        fin_rank  = rd_data.rank;
                    end
                    else
                    begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = start_node;
                        cur_next    = start_node;
                        state_next  = S_CMP;
                    end
                end
                else
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = rd_data.parent;
                    cur_next    = rd_data.parent;
                end
            end
            S_CMP:
            begin
                // Point this node at the root, keeping its rank.
                req.wr_en          = 1'b1;
                req.wr_addr        = cur_reg;
                req.wr_data.rank   = rd_data.rank;
                req.wr_data.parent = root_reg;
                if (rd_data.parent == root_reg)
                begin
                    phase_end = 1'b1;
                end
                else
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = rd_data.parent;
                    cur_next    = rd_data.parent;
                end
            end
            S_START_B:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = b_reg;
                cur_next    = b_reg;
                state_next  = S_UP;
            end
            S_LINK:
            begin
                if (ra_reg == root_reg)
                begin
                    joined_next = 1'b0;
                    state_next  = S_DONE;
                end
                else
                begin
                    joined_next = 1'b1;
                    if (rank_a_reg < root_rank_reg)
                    begin
                        hi_next      = root_reg;
                        hi_rank_next = root_rank_reg;
                        lo_node      = ra_reg;
                        lo_rank      = rank_a_reg;
                    end
                    else
                    begin
                        hi_next      = ra_reg;
                        hi_rank_next = rank_a_reg;
                        lo_node      = root_reg;
                        lo_rank      = root_rank_reg;
                    end
                    req.wr_en          = 1'b1;
                    req.wr_addr        = lo_node;
                    req.wr_data.rank   = lo_rank;
                    req.wr_data.parent = hi_next;
                    if ((rank_a_reg == root_rank_reg) && (rank_a_reg < ufef_pkg::RANK_MAX))
                    begin
                        state_next = S_BUMP;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_BUMP:
            begin
                req.wr_en          = 1'b1;
                req.wr_addr        = hi_reg;
                req.wr_data.rank   = hi_rank_reg + 1'b1;
                req.wr_data.parent = hi_reg;
                state_next         = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // End of one find: after the first endpoint, the spare state S_START_B keeps the
        // next read off the entry that the last compression write may be updating.
        if (phase_end)
        begin
            if (!phase_b_reg)
            begin
                ra_next      = fin_root;
                rank_a_next  = fin_rank;
                phase_b_next = 1'b1;
                state_next   = S_START_B;
            end
            else
            begin
                state_next = S_LINK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            phase_b_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            phase_b_reg <= phase_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        cur_reg       <= cur_next;
        root_reg      <= root_next;
        root_rank_reg <= root_rank_next;
        ra_reg        <= ra_next;
        rank_a_reg    <= rank_a_next;
        hi_reg        <= hi_next;
        hi_rank_reg   <= hi_rank_next;
        joined_reg    <= joined_next;
    end

endmodule

`default_nettype wire
